// ===== rtl/u8u16_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 decoder core.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int ByteW  = 8;
  localparam int UnitW  = 16;
  localparam int AccW   = 31;
  localparam int PendW  = 3;
  localparam int OffW   = 20;

  localparam logic [UnitW-1:0] HiSurBase = 16'hD800;
  localparam logic [UnitW-1:0] LoSurBase = 16'hDC00;
  localparam logic [OffW-1:0]  SupBase   = 20'h10000;

  // One result word.
  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             end_of_string;
    logic             last_of_run;
  } unit_t;

  // Results caused by one input byte, first one goes out first.
  typedef struct packed {
    logic [1:0] num;
    unit_t      first;
    unit_t      second;
  } dec_res_t;

  // Buffer status seen by the decode stage.
  typedef struct packed {
    logic can_load;
  } obuf_stat_t;

endpackage
`default_nettype wire

// ===== rtl/u8u16_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_if
// Valid/ready channels for input bytes and result code units.
// ----------------------------------------------------------------------------
interface u8u16_in_if;
  logic                       valid;
  logic                       ready;
  logic [u8u16_pkg::ByteW-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface u8u16_out_if;
  logic                        valid;
  logic                        ready;
  logic [u8u16_pkg::UnitW-1:0] code_unit;
  logic                        end_of_string;
  logic                        last_of_run;

  modport source (output valid, output code_unit, output end_of_string,
                  output last_of_run, input ready);
  modport sink   (input valid, input code_unit, input end_of_string,
                  input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/u8u16_dec.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_dec
// Input byte register, code point accumulator and single-pass decode.
// ----------------------------------------------------------------------------
module u8u16_dec (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  u8u16_in_if.sink                   in_if,
  input  wire u8u16_pkg::obuf_stat_t stat,
  output u8u16_pkg::dec_res_t        res,
  output logic                       load
);

  logic [u8u16_pkg::ByteW-1:0] byte_r;
  logic                        byte_v_r;
  logic [u8u16_pkg::AccW-1:0]  acc_r, acc_nxt;
  logic [u8u16_pkg::PendW-1:0] pend_r, pend_nxt;
  logic [u8u16_pkg::AccW-1:0]  acc_cat;
  logic [u8u16_pkg::OffW-1:0]  off;
  logic                        fire;

  assign acc_cat = {acc_r[u8u16_pkg::AccW-7:0], byte_r[5:0]};
  assign off     = acc_cat[u8u16_pkg::OffW-1:0] - u8u16_pkg::SupBase;

  always_comb begin
    res     = '0;
    acc_nxt = acc_r;
    pend_nxt = pend_r;
    if (pend_r == '0) begin
      if (byte_r == '0) begin
        res.num                 = 2'd1;
        res.first.end_of_string = 1'b1;
        res.first.last_of_run   = 1'b1;
      end else if (byte_r[7] == 1'b0) begin
        res.num               = 2'd1;
        res.first.code_unit   = {8'd0, byte_r};
        res.first.last_of_run = 1'b1;
      end else if (byte_r[7:5] == 3'b110) begin
        acc_nxt  = {26'd0, byte_r[4:0]};
        pend_nxt = 3'd1;
      end else if (byte_r[7:4] == 4'b1110) begin
        acc_nxt  = {27'd0, byte_r[3:0]};
        pend_nxt = 3'd2;
      end else if (byte_r[7:3] == 5'b11110) begin
        acc_nxt  = {28'd0, byte_r[2:0]};
        pend_nxt = 3'd3;
      end else if (byte_r[7:2] == 6'b111110) begin
        acc_nxt  = {29'd0, byte_r[1:0]};
        pend_nxt = 3'd4;
      end else if (byte_r[7:1] == 7'b1111110) begin
        acc_nxt  = {30'd0, byte_r[0]};
        pend_nxt = 3'd5;
      end
      // stray continuation and 0xFE/0xFF: drop
    end else begin
      pend_nxt = pend_r - 3'd1;
      acc_nxt  = acc_cat;
      if (pend_r == 3'd1) begin
        acc_nxt = '0;
        if (acc_cat[u8u16_pkg::AccW-1:16] == '0) begin
          res.num               = 2'd1;
          res.first.code_unit   = acc_cat[15:0];
          res.first.last_of_run = 1'b1;
        end else begin
          // surrogate pair, high unit first
          res.num                = 2'd2;
          res.first.code_unit    = u8u16_pkg::HiSurBase | {6'd0, off[19:10]};
          res.second.code_unit   = u8u16_pkg::LoSurBase | {6'd0, off[9:0]};
          res.second.last_of_run = 1'b1;
        end
      end
    end
  end

  assign fire        = byte_v_r && ((res.num == 2'd0) || stat.can_load);
  assign load        = fire && (res.num != 2'd0);
  assign in_if.ready = !byte_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_v_r <= 1'b0;
      acc_r    <= '0;
      pend_r   <= '0;
    end else begin
      if (fire) begin
        acc_r  <= acc_nxt;
        pend_r <= pend_nxt;
      end
      if (in_if.ready) begin
        byte_v_r <= in_if.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      byte_r <= in_if.byte_in;
    end
  end

  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd5) else $error("pending count out of range");

  a_held_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    byte_v_r && !fire |=> byte_v_r && $stable(byte_r) && $stable(pend_r))
    else $error("stalled byte lost or state moved");

endmodule
`default_nettype wire

// ===== rtl/u8u16_obuf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_obuf
// Two-entry result register; holds a surrogate pair while the sink stalls.
// ----------------------------------------------------------------------------
module u8u16_obuf (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire u8u16_pkg::dec_res_t res,
  input  wire logic                load,
  output u8u16_pkg::obuf_stat_t    stat,
  u8u16_out_if.source              out_if
);

  u8u16_pkg::unit_t head_r, tail_r;
  logic [1:0]       count_r, count_nxt;
  logic             pop;

  assign pop           = (count_r != 2'd0) && out_if.ready;
  assign stat.can_load = (count_r == 2'd0) || ((count_r == 2'd1) && pop);

  always_comb begin
    count_nxt = count_r;
    if (load) begin
      count_nxt = res.num;
    end else if (pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      head_r <= res.first;
      tail_r <= res.second;
    end else if (pop) begin
      // advance second word to the head
      head_r <= tail_r;
    end
  end

  assign out_if.valid         = (count_r != 2'd0);
  assign out_if.code_unit     = head_r.code_unit;
  assign out_if.end_of_string = head_r.end_of_string;
  assign out_if.last_of_run   = head_r.last_of_run;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("buffer count overflow");

  a_pair_head: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == 2'd2 |-> !head_r.last_of_run && tail_r.last_of_run)
    else $error("pair order broken");

endmodule
`default_nettype wire

// ===== rtl/utf8_to_utf16_decoder_core.sv =====
`default_nettype none
// Path: an accepted byte is held in the input byte register, decoded combinationally
//   and loaded into the result register, from which the sink takes its code units.
// Throughput: one byte per cycle while the sink keeps ready high; a surrogate pair
//   holds the result register until both units are taken, stalling further loads.
// Reset (synchronous, rst_n low) clears the accumulator, pending count, the
//   input valid flag and the result count; no clearing pass.
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_core
// UTF-8 byte stream to UTF-16 code units with end-of-string marking.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  u8u16_in_if.sink    in_if,
  u8u16_out_if.source out_if
);

  u8u16_pkg::dec_res_t   res;
  u8u16_pkg::obuf_stat_t stat;
  logic                  load;

  u8u16_dec u_dec (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .stat  (stat),
    .res   (res),
    .load  (load)
  );

  u8u16_obuf u_obuf (
    .clk    (clk),
    .rst_n  (rst_n),
    .res    (res),
    .load   (load),
    .stat   (stat),
    .out_if (out_if)
  );

endmodule
`default_nettype wire

// ===== tb/sv/u16_unit_tracker_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16_unit_tracker_pkg
// Tracks the decoder state for each accepted UTF-8 byte, predicts the UTF-16
// code units it causes and checks the units that the core puts out.
// ----------------------------------------------------------------------------
package u16_unit_tracker_pkg;
  import u8u16_pkg::*;

  class u16_unit_tracker;
    unit_t            due_units[$];
    logic [AccW-1:0]  code_acc;
    logic [PendW-1:0] cont_left;
    int               n_bytes;
    int               n_checked;
    int               n_errors;
    int               n_pairs;
    int               n_eos;

    function new();
      code_acc  = '0;
      cont_left = '0;
      n_bytes   = 0;
      n_checked = 0;
      n_errors  = 0;
      n_pairs   = 0;
      n_eos     = 0;
    endfunction

    function void push_unit(logic [UnitW-1:0] unit, logic eos, logic last);
      unit_t u;
      u.code_unit     = unit;
      u.end_of_string = eos;
      u.last_of_run   = last;
      due_units.push_back(u);
    endfunction

    // Advance the decoder by one accepted byte.
    function void note_byte(logic [ByteW-1:0] b);
      logic [AccW-1:0] cp;
      logic [AccW-1:0] ofs;
      n_bytes++;
      if (cont_left == 0) begin
        if (b == 8'h00) begin
          push_unit('0, 1'b1, 1'b1);
          n_eos++;
        end else if (!b[7]) begin
          push_unit({8'h00, b}, 1'b0, 1'b1);
        end else if (b[7:5] == 3'b110) begin
          code_acc  = AccW'(b[4:0]);
          cont_left = 3'd1;
        end else if (b[7:4] == 4'b1110) begin
          code_acc  = AccW'(b[3:0]);
          cont_left = 3'd2;
        end else if (b[7:3] == 5'b11110) begin
          code_acc  = AccW'(b[2:0]);
          cont_left = 3'd3;
        end else if (b[7:2] == 6'b111110) begin
          code_acc  = AccW'(b[1:0]);
          cont_left = 3'd4;
        end else if (b[7:1] == 7'b1111110) begin
          code_acc  = AccW'(b[0]);
          cont_left = 3'd5;
        end
        // stray continuation bytes and 0xFE/0xFF drop here
      end else begin
        // no prefix check: take the low six bits as they are
        code_acc  = {code_acc[AccW-7:0], b[5:0]};
        cont_left = cont_left - 3'd1;
        if (cont_left == 0) begin
          cp       = code_acc;
          code_acc = '0;
          if (cp < AccW'(SupBase)) begin
            push_unit(cp[UnitW-1:0], 1'b0, 1'b1);
          end else begin
            ofs = cp - AccW'(SupBase);
            push_unit(HiSurBase | UnitW'(ofs[19:10]), 1'b0, 1'b0);
            push_unit(LoSurBase | UnitW'(ofs[9:0]), 1'b0, 1'b1);
            n_pairs++;
          end
        end
      end
    endfunction

    function void check_unit(unit_t got);
      unit_t want;
      n_checked++;
      if (due_units.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR: unexpected word unit=%h eos=%b last=%b",
                   got.code_unit, got.end_of_string, got.last_of_run);
        return;
      end
      want = due_units.pop_front();
      if (got.code_unit !== want.code_unit || got.end_of_string !== want.end_of_string ||
          got.last_of_run !== want.last_of_run) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR: word %0d expected unit=%h eos=%b last=%b, got unit=%h eos=%b last=%b",
                   n_checked, want.code_unit, want.end_of_string, want.last_of_run,
                   got.code_unit, got.end_of_string, got.last_of_run);
      end
    endfunction

    function int outstanding();
      return due_units.size();
    endfunction
  endclass

endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives UTF-8 byte streams into the decoder core with random gaps on both
// channels and checks every UTF-16 word against a tracked prediction.
// ----------------------------------------------------------------------------
module tb;
  import u8u16_pkg::*;
  import u16_unit_tracker_pkg::*;

  localparam int NumBytes   = 1250;
  localparam int IdleLimit  = 400;
  localparam int DrainWait  = 10;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  u8u16_in_if  in_ch ();
  u8u16_out_if out_ch ();

  utf8_to_utf16_decoder_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  u16_unit_tracker unit_sb = new();

  bit calm[2];
  int idle_cycles = 0;

  logic [7:0] directed_bytes [25] = '{
    8'h00, 8'h7F, 8'h80, 8'hFF, 8'hFE,
    8'hC3, 8'hA9,
    8'hE2, 8'h82, 8'hAC,
    8'hF0, 8'h9F, 8'h98, 8'h80,
    8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
    8'hF8, 8'h00, 8'h40, 8'hC0, 8'hFF
  };

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Draw a random idle gap, with calm stretches that never idle.
  function automatic int draw_gap(input int side);
    if ($urandom_range(0, 39) == 0)
      calm[side] = !calm[side];
    return calm[side] ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap(0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.byte_in <= b;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    unit_sb.note_byte(b);
  endtask

  // Mostly well-formed sequences with random payload, some raw noise.
  task automatic send_random_run();
    int kind;
    int nbytes;
    logic [7:0] lead;
    logic [7:0] cont;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      if ($urandom_range(0, 19) == 0)
        send_byte(8'h00);
      else
        send_byte(8'($urandom_range(1, 127)));
    end else if (kind < 90) begin
      nbytes = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 6) : $urandom_range(2, 4);
      lead = (8'hFF << (8 - nbytes)) | (8'($urandom) & (8'hFF >> (nbytes + 1)));
      send_byte(lead);
      repeat (nbytes - 1) begin
        if ($urandom_range(0, 9) == 0)
          cont = 8'($urandom);
        else
          cont = {2'b10, 6'($urandom)};
        send_byte(cont);
      end
    end else begin
      send_byte(8'($urandom));
    end
  endtask

  // Result side: check each word, then hold ready low for a drawn stall.
  initial begin
    int stall;
    unit_t got;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.code_unit     = out_ch.code_unit;
        got.end_of_string = out_ch.end_of_string;
        got.last_of_run   = out_ch.last_of_run;
        unit_sb.check_unit(got);
        stall = draw_gap(1);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("ERROR: no handshake for %0d cycles, %0d words still due",
               idle_cycles, unit_sb.outstanding());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.byte_in <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_bytes[i])
      send_byte(directed_bytes[i]);
    while (unit_sb.n_bytes < NumBytes)
      send_random_run();
    in_ch.valid <= 1'b0;

    while (unit_sb.outstanding() != 0)
      @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("Run covered %0d bytes and %0d words checked (%0d surrogate pairs, %0d end markers).",
             unit_sb.n_bytes, unit_sb.n_checked, unit_sb.n_pairs, unit_sb.n_eos);
    $display("Mismatches: %0d, words still due: %0d", unit_sb.n_errors,
             unit_sb.outstanding());
    if (unit_sb.n_errors == 0 && unit_sb.outstanding() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/u8u16_pkg.sv
rtl/u8u16_if.sv
rtl/u8u16_dec.sv
rtl/u8u16_obuf.sv
rtl/utf8_to_utf16_decoder_core.sv
tb/sv/u16_unit_tracker_pkg.sv
tb/sv/tb.sv
